>>> rtl/frx_pkg.sv
// Package: shared types and constants of the framed packet receiver.
`timescale 1ns / 1ps
`default_nettype none

package frx_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_FRAMING = 2'd3
  } status_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  localparam logic [1:0] REG_START_BYTE    = 2'd0;
  localparam logic [1:0] REG_END_BYTE      = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [7:0] RST_START_BYTE    = 8'd2;
  localparam logic [7:0] RST_END_BYTE      = 8'd3;
  localparam logic [7:0] RST_TIMEOUT_TICKS = 8'd2;

  localparam logic [6:0] DATA_MASK = 7'h7f;
  localparam logic [2:0] POS_IDLE  = 3'd0;
  localparam logic [2:0] POS_FIRST = 3'd1;
  localparam logic [2:0] POS_SUM   = 3'd4;
  localparam logic [2:0] POS_LAST  = 3'd5;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] command;
    logic [13:0] value;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/frx_core.sv
// Frame state and per-item decode logic of the framed packet receiver.
`timescale 1ns / 1ps
`default_nettype none

module frx_core
  import frx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire opcode_t    opcode,
  input  wire logic [7:0] byte_value,
  input  wire cfg_t       cfg,
  output result_t         result
);

  logic [2:0] byte_position, byte_position_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] held_high, held_high_next;
  logic [7:0] held_low, held_low_next;
  logic [7:0] running_sum, running_sum_next;
  logic       checksum_ok, checksum_ok_next;
  logic [7:0] elapsed_ticks, elapsed_ticks_next;
  logic [7:0] ticks_inc;
  logic       done;
  status_t    done_status;

  assign ticks_inc = (elapsed_ticks == 8'hff) ? elapsed_ticks : elapsed_ticks + 8'd1;

  always_comb begin
    byte_position_next = byte_position;
    held_command_next  = held_command;
    held_high_next     = held_high;
    held_low_next      = held_low;
    running_sum_next   = running_sum;
    checksum_ok_next   = checksum_ok;
    elapsed_ticks_next = elapsed_ticks;
    done               = 1'b0;
    done_status        = ST_OK;
    if (opcode == OP_TICK) begin
      if (byte_position != POS_IDLE) begin
        elapsed_ticks_next = ticks_inc;
        if (ticks_inc >= cfg.timeout_ticks) begin
          done        = 1'b1;
          done_status = ST_TIMEOUT;
        end
      end
    end else if (byte_position == POS_IDLE) begin
      if (byte_value == cfg.start_byte) begin
        byte_position_next = POS_FIRST;
        running_sum_next   = byte_value;
        checksum_ok_next   = 1'b0;
        elapsed_ticks_next = 8'd0;
        held_command_next  = 8'd0;
        held_high_next     = 8'd0;
        held_low_next      = 8'd0;
      end
    end else if (byte_position >= POS_LAST) begin
      done = 1'b1;
      if (byte_value != cfg.end_byte) begin
        done_status = ST_FRAMING;
      end else if (checksum_ok) begin
        done_status = ST_OK;
      end else begin
        done_status = ST_BAD_SUM;
      end
    end else if (byte_value == cfg.end_byte) begin
      done        = 1'b1;
      done_status = ST_FRAMING;
    end else begin
      case (byte_position)
        3'd1: held_command_next = byte_value;
        3'd2: held_high_next    = byte_value;
        3'd3: held_low_next     = byte_value;
        default: checksum_ok_next = (running_sum == byte_value);
      endcase
      if (byte_position < POS_SUM) begin
        running_sum_next = running_sum + byte_value;
      end
      byte_position_next = byte_position + 3'd1;
    end
    if (done) begin
      byte_position_next = POS_IDLE;
      elapsed_ticks_next = 8'd0;
    end
  end

  always_comb begin
    result.valid   = done;
    result.status  = done_status;
    result.command = 8'd0;
    result.value   = 14'd0;
    if (done_status == ST_OK) begin
      result.command = held_command;
      result.value   = {held_high[6:0] & DATA_MASK, held_low[6:0] & DATA_MASK};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_IDLE;
      elapsed_ticks <= 8'd0;
    end else if (fire) begin
      byte_position <= byte_position_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_command <= held_command_next;
      held_high    <= held_high_next;
      held_low     <= held_low_next;
      running_sum  <= running_sum_next;
      checksum_ok  <= checksum_ok_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/framed_packet_receiver_unit.sv
// Top level: framed packet receiver with input register, config registers and result register.
//
//   channel  | dir | handshake                    | payload
//   s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: byte_value; tuser: opcode
//   m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: command, value; tuser: status
//   cfg      | in  | cfg_we                       | cfg_index, cfg_data
//
// One request per cycle unless m_axis stalls; results pass the input, then the result register.
// The input register feeds the frame logic, which writes the result register.
// A full, unaccepted result register holds the input register and s_axis_tready.
// Synchronous reset returns to hunting the start byte and restores config defaults.
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_receiver_unit
  import frx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic        s_axis_tuser,   // [0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] command, [21:8] value, [23:22] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic       in_valid;
  logic [7:0] in_byte;
  opcode_t    in_opcode;
  logic       advance;
  cfg_t       cfg;
  result_t    result;
  status_t    out_status;
  logic [7:0] out_command;
  logic [13:0] out_value;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= RST_START_BYTE;
      cfg.end_byte      <= RST_END_BYTE;
      cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE:    cfg.start_byte    <= cfg_data;
        REG_END_BYTE:      cfg.end_byte      <= cfg_data;
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte   <= s_axis_tdata;
      in_opcode <= opcode_t'(s_axis_tuser);
    end
  end

  frx_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .opcode     (in_opcode),
    .byte_value (in_byte),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= result.valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_status  <= result.status;
      out_command <= result.command;
      out_value   <= result.value;
    end
  end

  assign m_axis_tdata = {2'b00, out_value, out_command};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

>>> rtl/frx_checker.sv
// Checker: port-level assertions on the framed packet receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module frx_checker
  import frx_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == 24'd0)
    else $error("failed frame carries data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without matching request");

endmodule

bind framed_packet_receiver_unit frx_checker u_frx_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
